// ----- sv/sds_pkg.sv -----
package sds_pkg;

    // stencil size and row limit
    localparam int TAP_PAIRS  = 8;
    localparam int MAX_ROW    = 4096;
    localparam int COEF_SLOTS = 8;

    // field widths
    localparam int SMP_W  = 16;
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = SMP_W + DIFF_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = 36;
    localparam int COL_W  = 12;
    localparam int POS_W  = $clog2(MAX_ROW + 1);
    localparam int IDX_W  = $clog2(COEF_SLOTS);
    localparam int PAIRS  = COEF_SLOTS / 2;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [SMP_W-1:0]  t_coef;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // per-beat side information carried alongside the arithmetic
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             valid_res;
    } t_meta;

endpackage

// ----- sv/sds_cell.sv -----
module sds_cell
    import sds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_shift,
    input  t_smp  i_near,
    input  t_smp  i_far,
    input  t_coef i_coef,
    output t_smp  o_near,
    output t_smp  o_far,
    output t_prod o_prod
);

    t_smp  r_near;
    t_smp  r_far;
    t_prod r_prod;
    t_diff w_diff;
    t_prod n_prod;

    // weighted difference of the two held samples
    always_comb begin
        w_diff = t_diff'(r_near) - t_diff'(r_far);
        n_prod = t_prod'(i_coef) * t_prod'(w_diff);
    end

    // advance the two taps from the neighbours on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '0;
            r_far  <= '0;
        end else if (i_shift) begin
            r_near <= i_near;
            r_far  <= i_far;
        end
    end

    // hold the product while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_near = r_near;
    assign o_far  = r_far;
    assign o_prod = r_prod;

endmodule

// ----- sv/sds_sum.sv -----
module sds_sum
    import sds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_prod i_prod [COEF_SLOTS],
    output t_sum  o_sum
);

    t_pair r_pair [PAIRS];
    t_sum  r_sum;
    t_sum  n_sum;

    // first level: add neighbouring products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < PAIRS; k++) begin
                r_pair[k] <= t_pair'(i_prod[2*k]) + t_pair'(i_prod[2*k+1]);
            end
        end
    end

    // second level: total of the pair sums
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < PAIRS; k++) begin
            n_sum = n_sum + t_sum'(r_pair[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- sv/staggered_derivative_stencil_core.sv -----
// Staggered-grid first-derivative filter along one grid row. Each input beat
// carries one signed Q1.15 sample, tlast marking the row's final sample; each
// beat yields one output beat with the full-precision Q6.30 sum
// y = sum_j coef_j*(x[i+j] - x[i-j-1]), its column (input position minus
// seven) and a flag that is set only when the whole stencil lies inside the
// row and the sample is not the last of the row. One beat is taken per clock
// while the output is not stalled; a beat's result passes through four
// register stages: the cell row (tap shift, multiply) and the two-level adder
// tree. The pipeline only stalls while the output beat waits to be taken.
// The user must write coefficients through the configuration channel only
// while idle; the block itself does not enforce it.
module staggered_derivative_stencil_core
    import sds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [SMP_W-1:0]       i_cfg_data,
    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SMP_W-1:0]       s_axis_tdata,   // [15:0] sample
    input  logic                   s_axis_tlast,   // last_in_row
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SUM_W+COL_W-1:0] m_axis_tdata,   // [35:0] derivative, [47:36] column
    output logic                   m_axis_tuser    // valid_res
);

    t_coef            r_coef [COEF_SLOTS];
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_meta            n_meta;
    t_meta            r_meta_a, r_meta_b, r_meta_c, r_meta_d;
    logic             r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic             w_en;
    logic             w_accept;
    logic [POS_W-1:0] w_col_full;
    t_smp             w_near [TAP_PAIRS];
    t_smp             w_far  [TAP_PAIRS];
    t_prod            w_prod [COEF_SLOTS];
    t_sum             w_sum;

    // whole pipeline moves unless the output beat is waiting
    assign w_en          = !r_vld_d || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;
    assign o_cfg_ready   = 1'b1;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_SLOTS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= t_coef'(i_cfg_data);
        end
    end

    // row position, column and validity of the incoming beat
    always_comb begin
        w_col_full = r_pos - POS_W'(TAP_PAIRS - 1);
        n_meta.column    = (r_pos >= POS_W'(TAP_PAIRS - 1)) ? w_col_full[COL_W-1:0] : '0;
        n_meta.valid_res = (r_pos >= POS_W'(2*TAP_PAIRS - 1)) && !s_axis_tlast;
        if (s_axis_tlast) begin
            n_pos = '0;
        end else if (r_pos < POS_W'(MAX_ROW)) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    // valid bits follow the beat down the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (w_en) begin
            r_vld_a <= s_axis_tvalid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta_a <= n_meta;
            r_meta_b <= r_meta_a;
            r_meta_c <= r_meta_b;
            r_meta_d <= r_meta_c;
        end
    end

    // row of cells: cell k holds taps TAP_PAIRS-1-k and TAP_PAIRS+k
    for (genvar k = 0; k < TAP_PAIRS; k++) begin : g_cell
        t_smp w_near_in;
        t_smp w_far_in;

        if (k == TAP_PAIRS - 1) begin : g_head
            assign w_near_in = t_smp'(s_axis_tdata);
        end else begin : g_mid
            assign w_near_in = w_near[k+1];
        end

        if (k == 0) begin : g_turn
            assign w_far_in = w_near[0];
        end else begin : g_tail
            assign w_far_in = w_far[k-1];
        end

        sds_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (w_accept),
            .i_near  (w_near_in),
            .i_far   (w_far_in),
            .i_coef  (r_coef[k]),
            .o_near  (w_near[k]),
            .o_far   (w_far[k]),
            .o_prod  (w_prod[k])
        );
    end

    // unused slots add nothing
    for (genvar k = TAP_PAIRS; k < COEF_SLOTS; k++) begin : g_pad
        assign w_prod[k] = '0;
    end

    sds_sum u_sum (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_prod (w_prod),
        .o_sum  (w_sum)
    );

    // drop the sum where the stencil leaves the row
    assign m_axis_tvalid = r_vld_d;
    assign m_axis_tdata  = {r_meta_d.column, (r_meta_d.valid_res ? w_sum : t_sum'(0))};
    assign m_axis_tuser  = r_meta_d.valid_res;

endmodule
